### sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pps_pkg.sv
// Types and constants of the preemptive priority scheduler.
// Used by pps_cell and preemptive_priority_scheduler_top; depends on nothing.
`default_nettype none

package pps_pkg;

	localparam int LEN_BITS = 16;
	localparam int OUT_TIME_BITS = 16;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic op;
		logic [3:0] pid;
		logic [7:0] prio;
		logic [15:0] burst;
	} req_t;

	typedef struct packed {
		logic idle;
		logic [3:0] run_pid;
		logic [15:0] tick_time;
		logic done_res;
		logic [15:0] finish_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic [15:0] response;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic done;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### sv/pps_cell.sv
// One process slot of the scheduler chain: holds the slot and passes the best candidate on.
// Depends on pps_pkg and assert_macros.svh; instantiated by preemptive_priority_scheduler_top.
`default_nettype none
`include "assert_macros.svh"

module pps_cell #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 16,
	parameter int PRIO_BITS = 8,
	parameter int CELL_ID = 0,
	localparam int IW = $clog2(SLOTS),
	localparam int CAND_W = 2 + IW + PRIO_BITS + 2 * pps_pkg::LEN_BITS + 2 * TIME_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [IW-1:0] wr_id,
	input wire logic [PRIO_BITS-1:0] wr_prio,
	input wire logic [pps_pkg::LEN_BITS-1:0] wr_burst,
	input wire logic [TIME_BITS-1:0] wr_now,
	input wire pps_pkg::upd_t upd,
	input wire logic [IW-1:0] upd_id,
	input wire logic [TIME_BITS-1:0] upd_t0,
	input wire logic [CAND_W-1:0] cand_in,
	output logic [CAND_W-1:0] cand_out
);

	typedef struct packed {
		logic found;
		logic [IW-1:0] id;
		logic [PRIO_BITS-1:0] prio;
		logic [pps_pkg::LEN_BITS-1:0] ran;
		logic [pps_pkg::LEN_BITS-1:0] burst;
		logic [TIME_BITS-1:0] arrival;
		logic started;
		logic [TIME_BITS-1:0] first_run;
	} cand_t;

	localparam logic [IW-1:0] MY_ID = IW'(CELL_ID);

	logic valid_q;
	logic started_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [pps_pkg::LEN_BITS-1:0] burst_q;
	logic [pps_pkg::LEN_BITS-1:0] ran_q;
	logic [TIME_BITS-1:0] arrival_q;
	logic [TIME_BITS-1:0] first_run_q;
	cand_t cand_q;
	cand_t cin;
	cand_t self_c;
	cand_t nxt;
	logic wr_hit;
	logic upd_hit;

	assign wr_hit = wr_en && !valid_q && (wr_id == MY_ID);
	assign upd_hit = upd.en && (upd_id == MY_ID);
	assign cin = cand_t'(cand_in);
	assign cand_out = CAND_W'(cand_q);

	always_comb begin
		self_c.found = valid_q;
		self_c.id = MY_ID;
		self_c.prio = prio_q;
		self_c.ran = ran_q;
		self_c.burst = burst_q;
		self_c.arrival = arrival_q;
		self_c.started = started_q;
		self_c.first_run = first_run_q;
		if (valid_q && (!cin.found || (prio_q < cin.prio))) begin
			nxt = self_c;
		end else begin
			nxt = cin;
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			started_q <= 1'b0;
		end else if (wr_hit) begin
			valid_q <= 1'b1;
			started_q <= 1'b0;
		end else if (upd_hit) begin
			valid_q <= !upd.done;
			started_q <= !upd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			prio_q <= wr_prio;
			burst_q <= wr_burst;
			ran_q <= '0;
			arrival_q <= wr_now;
		end else if (upd_hit) begin
			ran_q <= ran_q + pps_pkg::LEN_BITS'(1);
			if (!started_q) begin
				first_run_q <= upd_t0;
			end
		end
	end

	`ASSERT_NEXT(a_done_frees, clk, arst_n, upd_hit && upd.done, !valid_q && !started_q, "Finished slot was not freed.")
	`ASSERT_NEXT(a_arrival_loads, clk, arst_n, wr_hit, valid_q && (ran_q == '0), "Arrival did not load its slot.")

endmodule

`default_nettype wire

### sv/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: a chain of slot cells and the tick sequencer.
// Depends on pps_pkg, pps_cell and assert_macros.svh.
//
// Usage: items enter on req (req_valid/req_ready). An arrival (op = 0) writes the
// slot named by pid and gives no result; it is ignored when the slot
// is occupied, the burst is zero or pid is beyond the table. A tick (op = 1) runs
// the ready process with the lowest priority number, ties to the lowest id, and
// gives one result item on rsp (rsp_valid/rsp_ready).
// A tick sweeps the candidate through the chain of SLOTS cells, one cell a cycle,
// then applies the update in ST_EVAL and loads the result register in ST_OUT;
// the next item can be taken in the same cycle that rsp_valid rises. Arrivals
// are taken only in ST_IDLE, while no tick is in progress.
// The result register holds a finished item while new arrivals and ticks enter;
// if the receiver stalls, a later tick waits in its last step until the register
// is free, and req_ready stays low meanwhile.
// Reset empties every slot and sets time to zero; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module preemptive_priority_scheduler_top #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 16,
	parameter int PRIO_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire pps_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output pps_pkg::rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int LB = pps_pkg::LEN_BITS;
	localparam int OB = pps_pkg::OUT_TIME_BITS;
	localparam int CAND_W = 2 + IW + PRIO_BITS + 2 * LB + 2 * TIME_BITS;
	localparam int WB = (TIME_BITS > LB) ? TIME_BITS : LB;
	localparam logic [WB-1:0] TMASK = WB'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef struct packed {
		logic found;
		logic [IW-1:0] id;
		logic [PRIO_BITS-1:0] prio;
		logic [LB-1:0] ran;
		logic [LB-1:0] burst;
		logic [TIME_BITS-1:0] arrival;
		logic started;
		logic [TIME_BITS-1:0] first_run;
	} cand_t;

	pps_pkg::state_t state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic [TIME_BITS-1:0] now_q;
	logic found_q;
	logic done_q;
	logic [IW-1:0] id_q;
	logic [TIME_BITS-1:0] t0_q;
	logic [TIME_BITS-1:0] tat_q;
	logic [TIME_BITS-1:0] resp_q;
	logic [LB-1:0] burst_q;
	logic rsp_valid_q;
	pps_pkg::rsp_t rsp_q;
	pps_pkg::rsp_t rsp_d;

	logic [CAND_W-1:0] chain [SLOTS+1];
	cand_t best;
	logic accept;
	logic wr_en;
	logic load_rsp;
	logic eval_done;
	logic [TIME_BITS-1:0] first_start;
	logic [WB-1:0] wait_full;
	pps_pkg::upd_t upd;

	assign accept = req_valid && req_ready;
	assign wr_en = accept && (req.op == pps_pkg::OP_ARRIVE) && (req.burst != '0)
		&& (int'(req.pid) < SLOTS);
	assign chain[0] = '0;
	assign best = cand_t'(chain[SLOTS]);
	assign eval_done = best.found && ((best.ran + LB'(1)) == best.burst);
	assign first_start = best.started ? best.first_run : now_q;
	assign upd = '{en: (state_q == pps_pkg::ST_EVAL) && best.found, done: eval_done};

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		pps_cell #(
			.SLOTS(SLOTS),
			.TIME_BITS(TIME_BITS),
			.PRIO_BITS(PRIO_BITS),
			.CELL_ID(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr_en(wr_en),
			.wr_id(IW'(req.pid)),
			.wr_prio(PRIO_BITS'(req.prio)),
			.wr_burst(req.burst),
			.wr_now(now_q),
			.upd(upd),
			.upd_id(best.id),
			.upd_t0(now_q),
			.cand_in(chain[g]),
			.cand_out(chain[g+1])
		);
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		load_rsp = 1'b0;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && (req.op == pps_pkg::OP_TICK)) begin
					state_d = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (cnt_q == LAST) begin
					state_d = pps_pkg::ST_EVAL;
				end
			end
			pps_pkg::ST_EVAL: begin
				state_d = pps_pkg::ST_OUT;
			end
			pps_pkg::ST_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		wait_full = (WB'(tat_q) - WB'(burst_q)) & TMASK;
		rsp_d = '0;
		rsp_d.idle = !found_q;
		rsp_d.tick_time = OB'(t0_q);
		if (found_q) begin
			rsp_d.run_pid = 4'(id_q);
		end
		if (done_q) begin
			rsp_d.done_res = 1'b1;
			rsp_d.finish_time = OB'(t0_q + TIME_BITS'(1));
			rsp_d.turnaround = OB'(tat_q);
			rsp_d.waiting = OB'(wait_full);
			rsp_d.response = OB'(resp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
			cnt_q <= '0;
			now_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pps_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == pps_pkg::ST_EVAL) begin
				now_q <= now_q + TIME_BITS'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::ST_EVAL) begin
			found_q <= best.found;
			done_q <= eval_done;
			id_q <= best.id;
			t0_q <= now_q;
			burst_q <= best.burst;
			tat_q <= (now_q + TIME_BITS'(1)) - best.arrival;
			resp_q <= first_start - best.arrival;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`ASSERT_NEXT(a_rsp_from_out, clk, arst_n, !rsp_valid_q && (state_q != pps_pkg::ST_OUT), !rsp_valid_q, "Result appeared without a finished tick.")
	`ASSERT_NEXT(a_time_step, clk, arst_n, state_q == pps_pkg::ST_EVAL, now_q == ($past(now_q) + TIME_BITS'(1)), "Time did not advance on a tick.")
	`ASSERT_PROP(a_done_not_idle, clk, arst_n, !(rsp_valid_q && rsp_q.done_res && rsp_q.idle), "Idle tick reported a finished process.")

endmodule

`default_nettype wire

### dv/pps_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the preemptive priority scheduler: it watches the request and
// result channels, schedules its own copy of the slot table and compares each result.
// Depends on pps_pkg.
module pps_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input pps_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input pps_pkg::rsp_t rsp,
	output int unsigned errors,
	output int unsigned pending
);

	localparam int SLOTS = 16;

	logic slot_busy [SLOTS];
	logic slot_begun [SLOTS];
	logic [7:0] slot_pri [SLOTS];
	logic [15:0] slot_len [SLOTS];
	logic [15:0] slot_used [SLOTS];
	logic [15:0] slot_arrived [SLOTS];
	logic [15:0] slot_first [SLOTS];
	logic [15:0] cur_time;
	pps_pkg::rsp_t tick_results [$];

	function automatic void store_arrival(input pps_pkg::req_t item);
		if (!slot_busy[item.pid] && item.burst != 16'd0) begin
			slot_busy[item.pid] = 1'b1;
			slot_begun[item.pid] = 1'b0;
			slot_pri[item.pid] = item.prio;
			slot_len[item.pid] = item.burst;
			slot_used[item.pid] = '0;
			slot_arrived[item.pid] = cur_time;
			slot_first[item.pid] = '0;
		end
	endfunction

	function automatic pps_pkg::rsp_t schedule_tick();
		pps_pkg::rsp_t r;
		int win;
		logic [15:0] tat;
		r = '0;
		win = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i] && (win < 0 || slot_pri[i] < slot_pri[win]))
				win = i;
		end
		r.tick_time = cur_time;
		cur_time = cur_time + 16'd1;
		if (win < 0) begin
			r.idle = 1'b1;
			return r;
		end
		r.run_pid = 4'(win);
		if (!slot_begun[win]) begin
			slot_begun[win] = 1'b1;
			slot_first[win] = r.tick_time;
		end
		slot_used[win] = slot_used[win] + 16'd1;
		if (slot_used[win] == slot_len[win]) begin
			tat = cur_time - slot_arrived[win];
			r.done_res = 1'b1;
			r.finish_time = cur_time;
			r.turnaround = tat;
			r.waiting = tat - slot_len[win];
			r.response = slot_first[win] - slot_arrived[win];
			slot_busy[win] = 1'b0;
			slot_begun[win] = 1'b0;
		end
		return r;
	endfunction

	function automatic string show(input pps_pkg::rsp_t r);
		return $sformatf("idle=%0d pid=%0d tick=%0d done=%0d finish=%0d tat=%0d wait=%0d resp=%0d",
			r.idle, r.run_pid, r.tick_time, r.done_res, r.finish_time, r.turnaround,
			r.waiting, r.response);
	endfunction

	always @(posedge clk) begin
		pps_pkg::rsp_t want;
		if (!arst_n) begin
			errors = 0;
			pending <= 0;
			cur_time = '0;
			tick_results.delete();
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i] = 1'b0;
				slot_begun[i] = 1'b0;
				slot_pri[i] = '0;
				slot_len[i] = '0;
				slot_used[i] = '0;
				slot_arrived[i] = '0;
				slot_first[i] = '0;
			end
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (tick_results.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected result: %s", $realtime, show(rsp));
					errors++;
				end else begin
					want = tick_results.pop_front();
					if (want.idle !== rsp.idle || want.run_pid !== rsp.run_pid ||
							want.tick_time !== rsp.tick_time ||
							want.done_res !== rsp.done_res ||
							want.finish_time !== rsp.finish_time ||
							want.turnaround !== rsp.turnaround ||
							want.waiting !== rsp.waiting ||
							want.response !== rsp.response) begin
						if (errors < 10) begin
							$display("%t expected %s", $realtime, show(want));
							$display("%t actual   %s", $realtime, show(rsp));
						end
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.op == pps_pkg::OP_TICK)
					tick_results.push_back(schedule_tick());
				else
					store_arrival(req);
			end
			pending <= tick_results.size();
		end
	end

endmodule

### dv/tb_preemptive_priority_scheduler_top.sv
`timescale 1ns / 100ps
// Testbench top of the preemptive priority scheduler: clock, reset, arrival and
// tick items with random gaps, result stalls and the verdict.
// Depends on pps_pkg, pps_checker and preemptive_priority_scheduler_top.
module tb_preemptive_priority_scheduler_top;

	localparam int SLOTS = 16;
	localparam int DRAIN_CYCLES = SLOTS + 8;
	localparam int RANDOM_ITEMS = 1700;
	localparam int TAIL_ITEMS = 200;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	pps_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	pps_pkg::rsp_t rsp;
	int unsigned errors;
	int unsigned pending;
	bit calm;
	bit hold_rsp;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	preemptive_priority_scheduler_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	pps_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	task automatic send_item(input pps_pkg::req_t item);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic arrive(input logic [3:0] pid, input logic [7:0] prio,
			input logic [15:0] burst);
		pps_pkg::req_t item;
		item.op = pps_pkg::OP_ARRIVE;
		item.pid = pid;
		item.prio = prio;
		item.burst = burst;
		send_item(item);
	endtask

	task automatic tick();
		pps_pkg::req_t item;
		{item.pid, item.prio, item.burst} = 28'($urandom);
		item.op = pps_pkg::OP_TICK;
		send_item(item);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		bit held;
		held = 1'b0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp && !held) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		#(64'd5_000_000);
		$display("preemptive_priority_scheduler_top: mismatch");
		$finish;
	end

	initial begin
		logic [3:0] pid;
		logic [7:0] prio;
		logic [15:0] burst;
		int unsigned pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick on the empty table, then ties, a refused zero burst and an
		// arrival to an occupied slot.
		send_item('{op: pps_pkg::OP_TICK, pid: 4'hf, prio: 8'hff, burst: 16'hffff});
		arrive(4'd0, 8'hff, 16'd2);
		arrive(4'd15, 8'h00, 16'd1);
		arrive(4'd15, 8'h05, 16'd3);
		arrive(4'd7, 8'h00, 16'd0);
		arrive(4'd3, 8'h00, 16'd2);
		tick();
		tick();
		tick();
		arrive(4'd15, 8'hff, 16'hffff);
		tick();
		arrive(4'd8, 8'h01, 16'd1);
		tick();
		tick();
		arrive(4'd0, 8'h00, 16'd5);
		tick();
		tick();
		tick();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 700)
				hold_rsp = 1'b1;
			if (n == 1300)
				wait_drained();
			if ($urandom_range(0, 99) < 65) begin
				tick();
			end else begin
				pid = 4'($urandom);
				prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				pick = $urandom_range(0, 127);
				if (pick < 6) begin
					burst = '0;
				end else if (pick == 127) begin
					burst = 16'($urandom);
					prio[7] = 1'b1;
				end else begin
					burst = 16'($urandom_range(1, 3));
				end
				arrive(pid, prio, burst);
			end
		end

		// Fast stretch without gaps at the end of the run.
		calm = 1'b1;
		for (int n = 0; n < TAIL_ITEMS; n++) begin
			if ($urandom_range(0, 3) != 0)
				tick();
			else
				arrive(4'($urandom), 8'($urandom), 16'($urandom_range(1, 16)));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("preemptive_priority_scheduler_top: match");
		else
			$display("preemptive_priority_scheduler_top: mismatch");
		$finish;
	end

endmodule
